>>> src/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> src/tekd_pkg.sv
// -----------------------------------------------------------------------------
// tekd_pkg
// Types, byte constants and key codes of the escape sequence key decoder.
// -----------------------------------------------------------------------------
package tekd_pkg;

    localparam logic [7:0] C_ESC   = 8'h1B;
    localparam logic [7:0] C_CSI   = 8'h5B;
    localparam logic [7:0] C_SS3   = 8'h4F;
    localparam logic [7:0] C_CTRL  = 8'h35;
    localparam logic [7:0] C_TILDE = 8'h7E;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [7:0] C_CH_A  = 8'h41;
    localparam logic [7:0] C_CH_B  = 8'h42;
    localparam logic [7:0] C_CH_C  = 8'h43;
    localparam logic [7:0] C_CH_D  = 8'h44;
    localparam logic [7:0] C_CH_H  = 8'h48;
    localparam logic [7:0] C_CH_F  = 8'h46;
    localparam logic [7:0] C_DIG_0 = 8'h30;
    localparam logic [7:0] C_DIG_1 = 8'h31;
    localparam logic [7:0] C_DIG_3 = 8'h33;
    localparam logic [7:0] C_DIG_4 = 8'h34;
    localparam logic [7:0] C_DIG_5 = 8'h35;
    localparam logic [7:0] C_DIG_6 = 8'h36;
    localparam logic [7:0] C_DIG_7 = 8'h37;
    localparam logic [7:0] C_DIG_8 = 8'h38;
    localparam logic [7:0] C_DIG_9 = 8'h39;

    localparam logic [3:0] K_LEFT   = 4'd0;
    localparam logic [3:0] K_RIGHT  = 4'd1;
    localparam logic [3:0] K_UP     = 4'd2;
    localparam logic [3:0] K_DOWN   = 4'd3;
    localparam logic [3:0] K_CLEFT  = 4'd4;
    localparam logic [3:0] K_DEL    = 4'd8;
    localparam logic [3:0] K_HOME   = 4'd9;
    localparam logic [3:0] K_END    = 4'd10;
    localparam logic [3:0] K_PGUP   = 4'd11;
    localparam logic [3:0] K_PGDN   = 4'd12;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ESC   = 3'd1,
        PH_INTRO = 3'd2,
        PH_DIGIT = 3'd3,
        PH_SEMI  = 3'd4,
        PH_MOD   = 3'd5
    } t_phase;

    typedef struct packed {
        logic       hit;
        logic [3:0] code;
    } t_key;

    typedef struct packed {
        t_phase     phase;
        logic       load_intro;
        logic       load_digit;
        logic       load_mod;
        logic       emit;
        logic       is_special;
        logic [7:0] key_code;
    } t_step;

    function automatic t_key arrow_code(input logic [7:0] b, input logic [3:0] base);
        t_key k;
        k.hit  = 1'b1;
        k.code = base;
        unique case (b)
            C_CH_A:  k.code = base + K_UP;
            C_CH_B:  k.code = base + K_DOWN;
            C_CH_C:  k.code = base + K_RIGHT;
            C_CH_D:  k.code = base + K_LEFT;
            default: k.hit  = 1'b0;
        endcase
        return k;
    endfunction

    function automatic t_key tilde_code(input logic [7:0] d);
        t_key k;
        k.hit  = 1'b1;
        k.code = K_HOME;
        unique case (d)
            C_DIG_1, C_DIG_7: k.code = K_HOME;
            C_DIG_3:          k.code = K_DEL;
            C_DIG_4, C_DIG_8: k.code = K_END;
            C_DIG_5:          k.code = K_PGUP;
            C_DIG_6:          k.code = K_PGDN;
            default:          k.hit  = 1'b0;
        endcase
        return k;
    endfunction

endpackage

>>> src/tekd_step.sv
// -----------------------------------------------------------------------------
// tekd_step
// Next parser phase and key result for one request.
// -----------------------------------------------------------------------------
module tekd_step (
    input  tekd_pkg::t_phase i_phase,
    input  logic [7:0]       i_intro,
    input  logic [7:0]       i_digit,
    input  logic [7:0]       i_modifier,
    input  logic             i_opcode,
    input  logic [7:0]       i_in_byte,
    output tekd_pkg::t_step  o_step
);

    tekd_pkg::t_key w_key;

    always_comb begin
        o_step            = '0;
        o_step.phase      = tekd_pkg::PH_IDLE;
        o_step.key_code   = tekd_pkg::C_ESC;
        w_key             = '0;

        if (i_opcode == tekd_pkg::OP_TIMEOUT) begin
            o_step.emit = (i_phase != tekd_pkg::PH_IDLE) &&
                          (i_phase <= tekd_pkg::PH_MOD);
        end else begin
            unique case (i_phase)
                tekd_pkg::PH_ESC: begin
                    o_step.load_intro = 1'b1;
                    o_step.phase      = tekd_pkg::PH_INTRO;
                end
                tekd_pkg::PH_INTRO: begin
                    o_step.load_digit = 1'b1;
                    if (i_intro == tekd_pkg::C_CSI) begin
                        w_key = tekd_pkg::arrow_code(i_in_byte, tekd_pkg::K_LEFT);
                    end
                    if (i_intro == tekd_pkg::C_CSI || i_intro == tekd_pkg::C_SS3) begin
                        if (i_in_byte == tekd_pkg::C_CH_H) begin
                            w_key = '{hit: 1'b1, code: tekd_pkg::K_HOME};
                        end
                        if (i_in_byte == tekd_pkg::C_CH_F) begin
                            w_key = '{hit: 1'b1, code: tekd_pkg::K_END};
                        end
                    end
                    if (i_intro == tekd_pkg::C_CSI && i_in_byte >= tekd_pkg::C_DIG_0 &&
                        i_in_byte <= tekd_pkg::C_DIG_9) begin
                        o_step.phase = tekd_pkg::PH_DIGIT;
                    end else begin
                        o_step.emit = 1'b1;
                    end
                end
                tekd_pkg::PH_DIGIT: begin
                    if (i_in_byte == tekd_pkg::C_SEMI) begin
                        o_step.phase = tekd_pkg::PH_SEMI;
                    end else begin
                        o_step.emit = 1'b1;
                        if (i_in_byte == tekd_pkg::C_TILDE) begin
                            w_key = tekd_pkg::tilde_code(i_digit);
                        end
                    end
                end
                tekd_pkg::PH_SEMI: begin
                    o_step.load_mod = 1'b1;
                    o_step.phase    = tekd_pkg::PH_MOD;
                end
                tekd_pkg::PH_MOD: begin
                    o_step.emit = 1'b1;
                    if (i_modifier == tekd_pkg::C_CTRL) begin
                        w_key = tekd_pkg::arrow_code(i_in_byte, tekd_pkg::K_CLEFT);
                    end
                end
                default: begin
                    if (i_in_byte == tekd_pkg::C_ESC) begin
                        o_step.phase = tekd_pkg::PH_ESC;
                    end else begin
                        o_step.emit     = 1'b1;
                        w_key           = '0;
                        o_step.key_code = i_in_byte;
                    end
                end
            endcase
            if (w_key.hit) begin
                o_step.is_special = 1'b1;
                o_step.key_code   = {4'd0, w_key.code};
            end
        end
    end

endmodule

>>> src/terminal_escape_key_decoder_core.sv
// -----------------------------------------------------------------------------
// terminal_escape_key_decoder_core
// Decodes terminal bytes and ESC sequences into plain or special keys.
// -----------------------------------------------------------------------------
// A key is registered in the output register, or in the skid while the output holds one.
// Throughput: one request per cycle while the skid register is empty.
// A two-entry output (register plus skid) keeps input ready while a key waits.
// Reset: synchronous, active low; parser returns to idle, output queue empties.
// -----------------------------------------------------------------------------
module terminal_escape_key_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_opcode,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_is_special,
    output logic [7:0] o_key_code
);

    tekd_pkg::t_phase r_phase;
    logic [7:0]       r_intro;
    logic [7:0]       r_digit;
    logic [7:0]       r_modifier;

    logic             r_out_valid;
    logic             r_out_special;
    logic [7:0]       r_out_code;
    logic             r_skid_valid;
    logic             r_skid_special;
    logic [7:0]       r_skid_code;

    logic             n_out_valid;
    logic             n_skid_valid;
    logic             w_load_out;
    logic             w_load_skid;
    logic             w_out_from_skid;

    tekd_pkg::t_step  w_step;
    logic             w_accept;
    logic             w_take;
    logic             w_emit;

    tekd_step u_step (
        .i_phase    (r_phase),
        .i_intro    (r_intro),
        .i_digit    (r_digit),
        .i_modifier (r_modifier),
        .i_opcode   (i_opcode),
        .i_in_byte  (i_in_byte),
        .o_step     (w_step)
    );

    assign o_ready  = !r_skid_valid;
    assign w_accept = i_valid && o_ready;
    assign w_take   = r_out_valid && i_ready;
    assign w_emit   = w_accept && w_step.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= tekd_pkg::PH_IDLE;
            r_intro    <= '0;
            r_digit    <= '0;
            r_modifier <= '0;
        end else if (w_accept) begin
            r_phase <= w_step.phase;
            if (w_step.load_intro) begin
                r_intro <= i_in_byte;
            end
            if (w_step.load_digit) begin
                r_digit <= i_in_byte;
            end
            if (w_step.load_mod) begin
                r_modifier <= i_in_byte;
            end
        end
    end

    always_comb begin
        n_out_valid     = r_out_valid;
        n_skid_valid    = r_skid_valid;
        w_load_out      = 1'b0;
        w_load_skid     = 1'b0;
        w_out_from_skid = 1'b0;
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                w_out_from_skid = 1'b1;
                n_out_valid     = 1'b1;
                n_skid_valid    = 1'b0;
            end else begin
                w_load_out  = w_emit;
                n_out_valid = w_emit;
            end
        end else if (w_emit) begin
            w_load_skid  = 1'b1;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_from_skid) begin
            r_out_special <= r_skid_special;
            r_out_code    <= r_skid_code;
        end else if (w_load_out) begin
            r_out_special <= w_step.is_special;
            r_out_code    <= w_step.key_code;
        end
        if (w_load_skid) begin
            r_skid_special <= w_step.is_special;
            r_skid_code    <= w_step.key_code;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_is_special = r_out_special;
    assign o_key_code   = r_out_code;

endmodule

>>> src/tekd_checker.sv
// -----------------------------------------------------------------------------
// tekd_checker
// Port-level checks of the key decoder, attached by bind.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module tekd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_rdy,
    input logic       i_key_vld,
    input logic       i_key_rdy,
    input logic       i_special,
    input logic [7:0] i_code
);

    logic       w_key_stall;
    logic [8:0] w_key;

    assign w_key_stall = i_key_vld && !i_key_rdy;
    assign w_key       = {i_special, i_code};

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, w_key_stall |=> i_key_vld && $stable(w_key))
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_key_vld && i_req_rdy)
    `ASSERT_CLK(a_special_range, i_clk, i_rst_n, i_key_vld && i_special |-> i_code <= 8'd12)
    `ASSERT_CLK(a_stall_needs_key, i_clk, i_rst_n, !i_req_rdy |-> i_key_vld)

endmodule

bind terminal_escape_key_decoder_core tekd_checker u_tekd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_req_rdy (o_ready),
    .i_key_vld (o_valid),
    .i_key_rdy (i_ready),
    .i_special (o_is_special),
    .i_code    (o_key_code)
);
